>>> rtl/bop_pkg.sv
// Shared types, field widths and register codes of the barrier option payoff block.
package bop_pkg;

    localparam int PRICE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DISC_BITS  = 17;
    localparam int DISC_FRAC  = 16;
    localparam int KIND_BITS  = 2;
    localparam int MODE_BITS  = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = (PRICE_BITS > DISC_BITS) ? PRICE_BITS : DISC_BITS;
    localparam int PROD_BITS   = PRICE_BITS + DISC_BITS;
    localparam int SCALED_BITS = PROD_BITS - DISC_FRAC;

    // Digital payoff of 1.0, clipped to the price range when there are no integer bits.
    localparam logic [PRICE_BITS-1:0] UNIT_VALUE = (FRAC_BITS >= PRICE_BITS) ?
        {PRICE_BITS{1'b1}} : ({{(PRICE_BITS-1){1'b0}}, 1'b1} << FRAC_BITS);

    localparam logic [PRICE_BITS-1:0] STRIKE_RESET   = PRICE_BITS'(6553600);
    localparam logic [PRICE_BITS-1:0] BARRIER_RESET  = PRICE_BITS'(7864320);
    localparam logic [DISC_BITS-1:0]  DISCOUNT_RESET = DISC_BITS'(65536);

    localparam logic [CFG_INDEX_BITS-1:0] REG_STRIKE   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_BARRIER  = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_DISCOUNT = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_KIND     = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE     = CFG_INDEX_BITS'(4);

    typedef enum logic [KIND_BITS-1:0] {
        KIND_CALL     = 2'd0,
        KIND_PUT      = 2'd1,
        KIND_DIG_CALL = 2'd2,
        KIND_DIG_PUT  = 2'd3
    } kind_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_NONE     = 3'd0,
        MODE_UP_OUT   = 3'd1,
        MODE_DOWN_OUT = 3'd2,
        MODE_UP_IN    = 3'd3,
        MODE_DOWN_IN  = 3'd4
    } mode_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] strike;
        logic [PRICE_BITS-1:0] barrier;
        logic [DISC_BITS-1:0]  discount;
        logic [KIND_BITS-1:0]  kind;
        logic [MODE_BITS-1:0]  mode;
    } cfg_t;

    // Gated, undiscounted payoff of one finished path.
    typedef struct packed {
        logic [PRICE_BITS-1:0] raw;
        logic                  hit;
    } pay_t;

endpackage

>>> rtl/bop_cfg_regs.sv
// Configuration register file of the barrier option payoff block.
module bop_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bop_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bop_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    output bop_pkg::cfg_t                       cfg
);

    bop_pkg::cfg_t cfg_reg;
    bop_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bop_pkg::REG_STRIKE:   cfg_next.strike   = cfg_wdata[bop_pkg::PRICE_BITS-1:0];
                bop_pkg::REG_BARRIER:  cfg_next.barrier  = cfg_wdata[bop_pkg::PRICE_BITS-1:0];
                bop_pkg::REG_DISCOUNT: cfg_next.discount = cfg_wdata[bop_pkg::DISC_BITS-1:0];
                bop_pkg::REG_KIND:     cfg_next.kind     = cfg_wdata[bop_pkg::KIND_BITS-1:0];
                bop_pkg::REG_MODE:     cfg_next.mode     = cfg_wdata[bop_pkg::MODE_BITS-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.strike   <= bop_pkg::STRIKE_RESET;
            cfg_reg.barrier  <= bop_pkg::BARRIER_RESET;
            cfg_reg.discount <= bop_pkg::DISCOUNT_RESET;
            cfg_reg.kind     <= bop_pkg::KIND_CALL;
            cfg_reg.mode     <= bop_pkg::MODE_NONE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/bop_path_stage.sv
// Input register, barrier monitor and undiscounted payoff of each path.
module bop_path_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  bop_pkg::cfg_t                    cfg,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bop_pkg::PRICE_BITS-1:0]   s_price_sample,
    input  logic                             s_first_sample,
    input  logic                             s_last_sample,
    output logic                             pay_valid,
    input  logic                             pay_ready,
    output bop_pkg::pay_t                    pay
);

    localparam int PB = bop_pkg::PRICE_BITS;

    logic          in_valid_reg, in_valid_next;
    logic [PB-1:0] price_reg;
    logic          first_reg;
    logic          last_reg;
    logic          crossed_reg, crossed_next;
    logic          pay_valid_reg, pay_valid_next;
    bop_pkg::pay_t pay_reg, pay_next;

    logic          pay_free;
    logic          in_go;
    logic          up_mode;
    logic          down_mode;
    logic          beyond;
    logic          crossed_now;
    logic          gate;
    logic [PB:0]   diff;
    logic          above_strike;
    logic          below_strike;
    logic [PB-1:0] raw;

    // Samples that do not close a path never need the payoff register.
    assign pay_free = !pay_valid_reg || pay_ready;
    assign in_go    = in_valid_reg && (!last_reg || pay_free);
    assign s_ready  = !in_valid_reg || in_go;

    assign up_mode   = (cfg.mode == bop_pkg::MODE_UP_OUT) || (cfg.mode == bop_pkg::MODE_UP_IN);
    assign down_mode = (cfg.mode == bop_pkg::MODE_DOWN_OUT) ||
                       (cfg.mode == bop_pkg::MODE_DOWN_IN);
    assign beyond    = (up_mode && (price_reg > cfg.barrier)) ||
                       (down_mode && (price_reg < cfg.barrier));
    assign crossed_now = !first_reg && (crossed_reg || beyond);

    always_comb begin
        unique case (cfg.mode)
            bop_pkg::MODE_UP_OUT, bop_pkg::MODE_DOWN_OUT: gate = !crossed_now;
            bop_pkg::MODE_UP_IN, bop_pkg::MODE_DOWN_IN:   gate = crossed_now;
            default:                                      gate = 1'b1;
        endcase
    end

    assign diff         = {1'b0, price_reg} - {1'b0, cfg.strike};
    assign below_strike = diff[PB];
    assign above_strike = !diff[PB] && (diff[PB-1:0] != '0);

    always_comb begin
        unique case (cfg.kind)
            bop_pkg::KIND_CALL:     raw = above_strike ? diff[PB-1:0] : '0;
            bop_pkg::KIND_PUT:      raw = below_strike ? (PB'(0) - diff[PB-1:0]) : '0;
            bop_pkg::KIND_DIG_CALL: raw = above_strike ? bop_pkg::UNIT_VALUE : '0;
            bop_pkg::KIND_DIG_PUT:  raw = below_strike ? bop_pkg::UNIT_VALUE : '0;
            default:                raw = '0;
        endcase
    end

    always_comb begin
        in_valid_next  = in_valid_reg;
        crossed_next   = crossed_reg;
        pay_valid_next = pay_valid_reg;
        pay_next       = pay_reg;
        if (pay_ready) begin
            pay_valid_next = 1'b0;
        end
        if (in_go) begin
            in_valid_next = 1'b0;
            // The closing sample leaves the flag clear for the next path.
            crossed_next  = last_reg ? 1'b0 : crossed_now;
            if (last_reg) begin
                pay_valid_next = 1'b1;
                pay_next.raw   = gate ? raw : '0;
                pay_next.hit   = crossed_now;
            end
        end
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            crossed_reg   <= 1'b0;
            pay_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            crossed_reg   <= crossed_next;
            pay_valid_reg <= pay_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            price_reg <= s_price_sample;
            first_reg <= s_first_sample;
            last_reg  <= s_last_sample;
        end
        pay_reg <= pay_next;
    end

    assign pay_valid = pay_valid_reg;
    assign pay       = pay_reg;

endmodule

>>> rtl/bop_discount.sv
// Discount multiplier with saturation and the result register.
module bop_discount (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [bop_pkg::DISC_BITS-1:0]    discount,
    input  logic                             pay_valid,
    output logic                             pay_ready,
    input  bop_pkg::pay_t                    pay,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bop_pkg::PRICE_BITS-1:0]   m_payoff_value,
    output logic                             m_barrier_hit
);

    localparam int PB = bop_pkg::PRICE_BITS;
    localparam int QB = bop_pkg::PROD_BITS;
    localparam int SB = bop_pkg::SCALED_BITS;

    logic          prod_valid_reg, prod_valid_next;
    logic [QB-1:0] prod_reg;
    logic          prod_hit_reg;
    logic          out_valid_reg, out_valid_next;
    logic [PB-1:0] value_reg;
    logic          hit_reg;

    logic          out_free;
    logic          prod_go;
    logic          prod_load;
    logic [QB-1:0] product;
    logic [SB-1:0] scaled;
    logic [PB-1:0] value_sat;

    assign out_free  = !out_valid_reg || m_ready;
    assign prod_go   = prod_valid_reg && out_free;
    assign pay_ready = !prod_valid_reg || prod_go;
    assign prod_load = pay_valid && pay_ready;

    assign product = QB'(pay.raw) * QB'(discount);

    // Dropping the discount's fraction bits truncates; anything above the price range clips.
    assign scaled    = prod_reg[QB-1:bop_pkg::DISC_FRAC];
    assign value_sat = ((scaled >> PB) != '0) ? {PB{1'b1}} : scaled[PB-1:0];

    always_comb begin
        prod_valid_next = prod_valid_reg;
        out_valid_next  = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (prod_go) begin
            prod_valid_next = 1'b0;
            out_valid_next  = 1'b1;
        end
        if (prod_load) begin
            prod_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_load) begin
            prod_reg     <= product;
            prod_hit_reg <= pay.hit;
        end
        if (prod_go) begin
            value_reg <= value_sat;
            hit_reg   <= prod_hit_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_payoff_value = value_reg;
    assign m_barrier_hit  = hit_reg;

endmodule

>>> rtl/barrier_option_payoff.sv
// Top level of the barrier option payoff block: configuration, path monitor and discount.
//
// Price samples of simulated paths enter on the s_ channel, one sample per beat, with
// s_first_sample marking the first sample of a path and s_last_sample its final one.
// Every sample after the first is checked against the barrier; the final sample of a
// path yields one beat on the m_ channel carrying the discounted payoff and the flag
// that tells whether the barrier was crossed. Other samples produce no output beat.
// Registers are written over the cfg_ channel, which is always ready, and should only
// change while no path sample is in flight.
// A sample can be accepted in every cycle while m_ready does not stall the pipeline. A
// closing sample reaches m_valid through these registers in order: the beat lands in the
// input register, the payoff and barrier logic load the payoff register, the discount
// multiplier loads the product register, and saturation loads the output register.
// When the receiver holds m_ready low the pipeline fills up and s_ready drops only once
// every stage holding a closing sample is occupied; samples that close no path still
// pass through the monitor stage.
// Reset is synchronous and active low; it restores the register defaults, clears the
// crossed flag and empties the pipeline.
module barrier_option_payoff (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bop_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bop_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bop_pkg::PRICE_BITS-1:0]      s_price_sample,
    input  logic                                s_first_sample,
    input  logic                                s_last_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bop_pkg::PRICE_BITS-1:0]      m_payoff_value,
    output logic                                m_barrier_hit
);

    bop_pkg::cfg_t cfg;
    bop_pkg::pay_t pay;
    logic          pay_valid;
    logic          pay_ready;

    bop_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bop_path_stage u_path_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_price_sample (s_price_sample),
        .s_first_sample (s_first_sample),
        .s_last_sample  (s_last_sample),
        .pay_valid      (pay_valid),
        .pay_ready      (pay_ready),
        .pay            (pay)
    );

    bop_discount u_discount (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .discount       (cfg.discount),
        .pay_valid      (pay_valid),
        .pay_ready      (pay_ready),
        .pay            (pay),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payoff_value (m_payoff_value),
        .m_barrier_hit  (m_barrier_hit)
    );

endmodule
